>>> rtl/core/hsl_pkg.sv
// Package for the HSL to RGB converter: widths, scaling constants and the
// sextant type. No dependencies.
package hsl_pkg;

   localparam int unsigned HueWidth     = 9;
   localparam int unsigned PctWidth     = 7;
   localparam int unsigned ChanWidth    = 8;
   localparam int unsigned SextWidth    = 3;
   localparam int unsigned OffWidth     = 6;
   localparam int unsigned ChromaWidth  = 14;
   localparam int unsigned UnitWidth    = 20;
   localparam int unsigned SumWidth     = 21;
   localparam int unsigned ScaledWidth  = 26;
   localparam int unsigned RecipWidth   = 19;
   localparam int unsigned RecipShift   = 28;
   localparam int unsigned FracShift    = 6;
   localparam int unsigned Depth        = 6;

   localparam int unsigned HueFull      = 360;
   localparam int unsigned DegSextant   = 60;
   localparam int unsigned PctFull      = 100;
   localparam int unsigned ChanMax      = 255;
   localparam int unsigned UnitDen      = 600000;
   localparam int unsigned UnitPerPct   = UnitDen / PctFull;
   localparam int unsigned HalfSextant  = DegSextant / 2;
   // (v*510 + 600000) / 1200000 reduced by 30, then /64 and /625
   localparam int unsigned ScaleMul     = (2 * ChanMax) / 30;
   localparam int unsigned ScaleBias    = UnitDen / 30;
   localparam int unsigned ScaleDivOdd  = (2 * UnitDen / 30) / (1 << FracShift);
   localparam int unsigned RecipMul     =
      ((1 << RecipShift) + ScaleDivOdd - 1) / ScaleDivOdd;

   typedef logic [SextWidth-1:0] sext_type;

   localparam sext_type SextRedYellow    = SextWidth'(0);
   localparam sext_type SextYellowGreen  = SextWidth'(1);
   localparam sext_type SextGreenCyan    = SextWidth'(2);
   localparam sext_type SextCyanBlue     = SextWidth'(3);
   localparam sext_type SextBlueMagenta  = SextWidth'(4);
   localparam sext_type SextMagentaRed   = SextWidth'(5);

   typedef struct packed {
      logic [UnitWidth-1:0] c_u;
      logic [UnitWidth-1:0] x_u;
      logic [UnitWidth-1:0] m_u;
   } terms_type;

endpackage

>>> rtl/core/hsl_to_rgb_converter.sv
// HSL to RGB converter top level: six-stage pipeline, one item per clock.
// Depends on hsl_pkg.
//
// One colour is taken per clock (start while busy is low) and its RGB result
// appears on rsp_red/green/blue with rsp_valid high for one cycle, after passing
// through the six pipeline stages; busy is never raised as the result side cannot
// stall and the pipeline has no loop. Hue wraps modulo 360, percentages above 100
// count as 100, channels are rounded half up.
module hsl_to_rgb_converter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [hsl_pkg::HueWidth-1:0]    req_hue_deg,
   input  logic [hsl_pkg::PctWidth-1:0]    req_sat_pct,
   input  logic [hsl_pkg::PctWidth-1:0]    req_light_pct,
   output logic                            rsp_valid,
   output logic [hsl_pkg::ChanWidth-1:0]   rsp_red,
   output logic [hsl_pkg::ChanWidth-1:0]   rsp_green,
   output logic [hsl_pkg::ChanWidth-1:0]   rsp_blue
);
   import hsl_pkg::*;

   logic [Depth-1:0] valid_ff, valid_in;

   // stage 1: wrap, clamp, sextant
   logic [HueWidth-1:0]  hue_w;
   logic [PctWidth-1:0]  sat_w, lit_w, dist_w;
   logic [PctWidth:0]    lit2_w;
   logic [HueWidth-1:0]  base_w;
   logic [OffWidth-1:0]  off_w;
   sext_type             sext_in;
   logic [OffWidth-1:0]  xf_in;
   logic [PctWidth-1:0]  cl_in;
   sext_type             s1_sext_ff;
   logic [OffWidth-1:0]  s1_xf_ff;
   logic [PctWidth-1:0]  s1_cl_ff, s1_sat_ff, s1_lit_ff;

   // stage 2: chroma
   logic [ChromaWidth-1:0] cn_in, s2_cn_ff;
   sext_type               s2_sext_ff;
   logic [OffWidth-1:0]    s2_xf_ff;
   logic [PctWidth-1:0]    s2_lit_ff;

   // stage 3: C, X, m
   terms_type terms_in, s3_terms_ff;
   sext_type  s3_sext_ff;

   // stage 4: channel sums
   logic [SumWidth-1:0] r_in, g_in, b_in, s4_r_ff, s4_g_ff, s4_b_ff;
   logic [UnitWidth-1:0] r_sel, g_sel, b_sel;

   // stage 5: scale and drop low bits
   logic [ScaledWidth-FracShift-1:0] a_r_in, a_g_in, a_b_in, s5_r_ff, s5_g_ff, s5_b_ff;

   // stage 6: reciprocal multiply
   logic [ChanWidth-1:0] q_r_in, q_g_in, q_b_in;
   logic [ChanWidth-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   function automatic logic [ScaledWidth-FracShift-1:0] scale_down(
      input logic [SumWidth-1:0] v);
      logic [ScaledWidth-1:0] n;
      n = ScaledWidth'(v) * ScaledWidth'(ScaleMul) + ScaledWidth'(ScaleBias);
      return n[ScaledWidth-1:FracShift];
   endfunction

   function automatic logic [ChanWidth-1:0] recip_div(
      input logic [ScaledWidth-FracShift-1:0] a);
      logic [ScaledWidth-FracShift+RecipWidth-1:0] p;
      logic [ScaledWidth-FracShift+RecipWidth-RecipShift-1:0] q;
      p = (ScaledWidth-FracShift+RecipWidth)'(a)
          * (ScaledWidth-FracShift+RecipWidth)'(RecipMul);
      q = p[ScaledWidth-FracShift+RecipWidth-1:RecipShift];
      return (q > ChanMax) ? ChanWidth'(ChanMax) : q[ChanWidth-1:0];
   endfunction

   assign busy = 1'b0;
   assign valid_in = {valid_ff[Depth-2:0], start & ~busy};

   always_comb begin
      hue_w = (req_hue_deg >= HueWidth'(HueFull)) ? req_hue_deg - HueWidth'(HueFull)
                                                  : req_hue_deg;
      sat_w = (req_sat_pct > PctWidth'(PctFull)) ? PctWidth'(PctFull) : req_sat_pct;
      lit_w = (req_light_pct > PctWidth'(PctFull)) ? PctWidth'(PctFull) : req_light_pct;
      sext_in = '0;
      for (int k = 1; k < 6; k++) begin
         if (hue_w >= HueWidth'(k * DegSextant)) sext_in = SextWidth'(k);
      end
      base_w = HueWidth'(sext_in) * HueWidth'(DegSextant);
      off_w  = OffWidth'(hue_w - base_w);
      xf_in  = sext_in[0] ? OffWidth'(DegSextant) - off_w : off_w;
      lit2_w = {lit_w, 1'b0};
      dist_w = (lit2_w >= (PctWidth+1)'(PctFull)) ? PctWidth'(lit2_w - (PctWidth+1)'(PctFull))
                                                 : PctWidth'((PctWidth+1)'(PctFull) - lit2_w);
      cl_in  = PctWidth'(PctFull) - dist_w;
   end

   assign cn_in = ChromaWidth'(s1_cl_ff) * ChromaWidth'(s1_sat_ff);

   always_comb begin
      terms_in.c_u = UnitWidth'(s2_cn_ff) * UnitWidth'(DegSextant);
      terms_in.x_u = UnitWidth'(s2_cn_ff) * UnitWidth'(s2_xf_ff);
      terms_in.m_u = UnitWidth'(s2_lit_ff) * UnitWidth'(UnitPerPct)
                     - UnitWidth'(s2_cn_ff) * UnitWidth'(HalfSextant);
   end

   always_comb begin
      case (s3_sext_ff)
         SextRedYellow: begin
            r_sel = s3_terms_ff.c_u; g_sel = s3_terms_ff.x_u; b_sel = '0;
         end
         SextYellowGreen: begin
            r_sel = s3_terms_ff.x_u; g_sel = s3_terms_ff.c_u; b_sel = '0;
         end
         SextGreenCyan: begin
            r_sel = '0; g_sel = s3_terms_ff.c_u; b_sel = s3_terms_ff.x_u;
         end
         SextCyanBlue: begin
            r_sel = '0; g_sel = s3_terms_ff.x_u; b_sel = s3_terms_ff.c_u;
         end
         SextBlueMagenta: begin
            r_sel = s3_terms_ff.x_u; g_sel = '0; b_sel = s3_terms_ff.c_u;
         end
         SextMagentaRed: begin
            r_sel = s3_terms_ff.c_u; g_sel = '0; b_sel = s3_terms_ff.x_u;
         end
         default: begin
            r_sel = '0; g_sel = '0; b_sel = '0;
         end
      endcase
      r_in = SumWidth'(r_sel) + SumWidth'(s3_terms_ff.m_u);
      g_in = SumWidth'(g_sel) + SumWidth'(s3_terms_ff.m_u);
      b_in = SumWidth'(b_sel) + SumWidth'(s3_terms_ff.m_u);
   end

   assign a_r_in = scale_down(s4_r_ff);
   assign a_g_in = scale_down(s4_g_ff);
   assign a_b_in = scale_down(s4_b_ff);
   assign q_r_in = recip_div(s5_r_ff);
   assign q_g_in = recip_div(s5_g_ff);
   assign q_b_in = recip_div(s5_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sext_ff   <= sext_in;
      s1_xf_ff     <= xf_in;
      s1_cl_ff     <= cl_in;
      s1_sat_ff    <= sat_w;
      s1_lit_ff    <= lit_w;
      s2_cn_ff     <= cn_in;
      s2_sext_ff   <= s1_sext_ff;
      s2_xf_ff     <= s1_xf_ff;
      s2_lit_ff    <= s1_lit_ff;
      s3_terms_ff  <= terms_in;
      s3_sext_ff   <= s2_sext_ff;
      s4_r_ff      <= r_in;
      s4_g_ff      <= g_in;
      s4_b_ff      <= b_in;
      s5_r_ff      <= a_r_in;
      s5_g_ff      <= a_g_in;
      s5_b_ff      <= a_b_in;
      rsp_red_ff   <= q_r_in;
      rsp_green_ff <= q_g_in;
      rsp_blue_ff  <= q_b_in;
   end

   assign rsp_valid = valid_ff[Depth-1];
   assign rsp_red   = rsp_red_ff;
   assign rsp_green = rsp_green_ff;
   assign rsp_blue  = rsp_blue_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      start |-> ##6 rsp_valid)
      else $error("item lost in pipeline");

   a_x_le_c : assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> s3_terms_ff.x_u <= s3_terms_ff.c_u)
      else $error("X exceeds chroma");

   a_unit_range : assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> (s4_r_ff <= SumWidth'(UnitDen)) && (s4_g_ff <= SumWidth'(UnitDen))
                      && (s4_b_ff <= SumWidth'(UnitDen)))
      else $error("channel sum out of range");

   a_grey : assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && s2_cn_ff == '0 |-> ##4 (rsp_red == rsp_green) && (rsp_green == rsp_blue))
      else $error("grey item not neutral");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for hsl_to_rgb_converter: directed and random HSL items are
// converted by an exact integer model and compared channel by channel.
// Depends on hsl_pkg and the converter RTL.
module testbench;
   import hsl_pkg::*;

   typedef struct packed {
      logic [HueWidth-1:0] hue;
      logic [PctWidth-1:0] sat;
      logic [PctWidth-1:0] light;
   } hsl_item_type;

   typedef struct packed {
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
   } rgb_type;

   localparam int unsigned RandomItems  = 400;
   localparam int unsigned CalmFirst    = 150;
   localparam int unsigned CalmLast     = 260;
   localparam int unsigned StallLimit   = 2000;
   localparam int unsigned SettleCycles = 2 * Depth + 4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [HueWidth-1:0] req_hue_deg = '0;
   logic [PctWidth-1:0] req_sat_pct = '0;
   logic [PctWidth-1:0] req_light_pct = '0;
   logic rsp_valid;
   logic [ChanWidth-1:0] rsp_red;
   logic [ChanWidth-1:0] rsp_green;
   logic [ChanWidth-1:0] rsp_blue;

   hsl_item_type pending_hsl_q[$];
   rgb_type      expected_rgb_q[$];
   int unsigned  items_taken = 0;
   int unsigned  error_count = 0;
   int unsigned  stall_cycles = 0;

   hsl_to_rgb_converter u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_hue_deg   (req_hue_deg),
      .req_sat_pct   (req_sat_pct),
      .req_light_pct (req_light_pct),
      .rsp_valid     (rsp_valid),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [ChanWidth-1:0] channel_level(input int unsigned level_u);
      longint unsigned q;
      q = (longint'(level_u) * (2 * ChanMax) + UnitDen) / (2 * longint'(UnitDen));
      if (q > ChanMax) begin
         q = longint'(ChanMax);
      end
      return q[ChanWidth-1:0];
   endfunction

   function automatic rgb_type rgb_of_hsl(input hsl_item_type item);
      int unsigned hue, sat, lit, two_l, hmod, cn, c_u, x_u, m_u;
      int unsigned r_u, g_u, b_u;
      sext_type sext;
      rgb_type rgb;
      hue = item.hue % HueFull;
      sat = (item.sat > PctFull) ? PctFull : item.sat;
      lit = (item.light > PctFull) ? PctFull : item.light;
      two_l = 2 * lit;
      cn = (PctFull - ((two_l > PctFull) ? two_l - PctFull : PctFull - two_l)) * sat;
      c_u = cn * DegSextant;
      hmod = hue % (2 * DegSextant);
      x_u = cn * (DegSextant - ((hmod > DegSextant) ? hmod - DegSextant : DegSextant - hmod));
      m_u = lit * UnitPerPct - cn * HalfSextant;
      sext = sext_type'(hue / DegSextant);
      case (sext)
         SextRedYellow: begin
            r_u = c_u; g_u = x_u; b_u = 0;
         end
         SextYellowGreen: begin
            r_u = x_u; g_u = c_u; b_u = 0;
         end
         SextGreenCyan: begin
            r_u = 0; g_u = c_u; b_u = x_u;
         end
         SextCyanBlue: begin
            r_u = 0; g_u = x_u; b_u = c_u;
         end
         SextBlueMagenta: begin
            r_u = x_u; g_u = 0; b_u = c_u;
         end
         SextMagentaRed: begin
            r_u = c_u; g_u = 0; b_u = x_u;
         end
         default: begin
            r_u = 0; g_u = 0; b_u = 0;
         end
      endcase
      rgb.red   = channel_level(r_u + m_u);
      rgb.green = channel_level(g_u + m_u);
      rgb.blue  = channel_level(b_u + m_u);
      return rgb;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic queue_colour(input int unsigned hue, input int unsigned sat,
                               input int unsigned light);
      hsl_item_type item;
      item.hue   = hue[HueWidth-1:0];
      item.sat   = sat[PctWidth-1:0];
      item.light = light[PctWidth-1:0];
      pending_hsl_q.push_back(item);
   endtask

   always @(posedge clock) begin : driver
      hsl_item_type taken_item;
      logic         idle;
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         start <= 1'b1;
      end else begin
         if (start) begin
            taken_item = pending_hsl_q.pop_front();
            expected_rgb_q.push_back(rgb_of_hsl(taken_item));
            items_taken++;
         end
         idle = (items_taken < CalmFirst || items_taken >= CalmLast) &&
                ($urandom_range(99) < 33);
         if (pending_hsl_q.size() != 0 && !idle) begin
            start         <= 1'b1;
            req_hue_deg   <= pending_hsl_q[0].hue;
            req_sat_pct   <= pending_hsl_q[0].sat;
            req_light_pct <= pending_hsl_q[0].light;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      rgb_type want;
      if (!reset && rsp_valid) begin
         if (expected_rgb_q.size() == 0) begin
            report_mismatch("unexpected result, red", int'(rsp_red), -1);
         end else begin
            want = expected_rgb_q.pop_front();
            if (rsp_red !== want.red) begin
               report_mismatch("red", int'(rsp_red), int'(want.red));
            end
            if (rsp_green !== want.green) begin
               report_mismatch("green", int'(rsp_green), int'(want.green));
            end
            if (rsp_blue !== want.blue) begin
               report_mismatch("blue", int'(rsp_blue), int'(want.blue));
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= StallLimit) begin
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned hue, sat, light;
      // sextant edges, zero saturation, grey extremes, wrapped hue and clamped percent
      queue_colour(0, 100, 50);
      queue_colour(59, 100, 50);
      queue_colour(60, 100, 50);
      queue_colour(119, 100, 50);
      queue_colour(120, 100, 50);
      queue_colour(180, 100, 50);
      queue_colour(240, 100, 50);
      queue_colour(300, 100, 50);
      queue_colour(359, 100, 50);
      queue_colour(200, 0, 0);
      queue_colour(200, 0, 100);
      queue_colour(200, 0, 37);
      queue_colour(90, 100, 0);
      queue_colour(90, 100, 100);
      queue_colour(30, 1, 1);
      queue_colour(360, 100, 50);
      queue_colour(511, 100, 50);
      queue_colour(150, 127, 50);
      queue_colour(270, 80, 127);
      queue_colour(511, 127, 127);
      queue_colour(0, 0, 0);
      queue_colour(330, 55, 49);
      queue_colour(45, 73, 51);
      for (int i = 0; i < RandomItems; i++) begin
         case ($urandom_range(9))
            0: begin
               hue   = $urandom_range((1 << HueWidth) - 1);
               sat   = $urandom_range((1 << PctWidth) - 1);
               light = $urandom_range((1 << PctWidth) - 1);
            end
            1: begin
               hue   = DegSextant * $urandom_range(5) + $urandom_range(1) * (DegSextant - 1);
               sat   = $urandom_range(PctFull);
               light = $urandom_range(PctFull);
            end
            default: begin
               hue   = $urandom_range(HueFull - 1);
               sat   = $urandom_range(PctFull);
               light = $urandom_range(PctFull);
            end
         endcase
         queue_colour(hue, sat, light);
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (pending_hsl_q.size() != 0 || expected_rgb_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
